[design/ole_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared constants, operation and status codes and state types.
// ----------------------------------------------------------------------------
`default_nettype none
package ole_pkg;
  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int MaxOut        = 16;

  typedef enum logic [3:0] {
    OP_CLEAR   = 4'd0,
    OP_SORTED  = 4'd1,
    OP_INS_FR  = 4'd2,
    OP_INS_BK  = 4'd3,
    OP_DEL_KEY = 4'd4,
    OP_DEL_FR  = 4'd5,
    OP_DEL_BK  = 4'd6,
    OP_REVERSE = 4'd7,
    OP_READ    = 4'd8
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_RESP  = 2'd2,
    S_READ  = 2'd3
  } state_t;

  // Per-cell command broadcast by the controller.
  typedef enum logic [2:0] {
    C_HOLD  = 3'd0,
    C_INS   = 3'd1,
    C_DEL   = 3'd2,
    C_REV   = 3'd3,
    C_SHL   = 3'd4
  } cmd_t;
endpackage
`default_nettype wire

[design/ole_if.sv]
// ----------------------------------------------------------------------------
// Ordered list engine channels
// Valid/ready channel interfaces for operation words and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface ole_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic signed [31:0] key_value;
  modport source (output valid, op, key_value, input ready);
  modport sink   (input valid, op, key_value, output ready);
endinterface

interface ole_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] entry_key;
  logic [3:0]  entry_position;
  logic [4:0]  entry_count;
  logic [1:0]  status;
  logic        last_result;
  modport source (output valid, entry_key, entry_position, entry_count, status,
                  last_result, input ready);
  modport sink   (input valid, entry_key, entry_position, entry_count, status,
                  last_result, output ready);
endinterface
`default_nettype wire

[design/ole_cell.sv]
// ----------------------------------------------------------------------------
// Ordered list engine cell
// One slot of the list; takes its next key from itself, a neighbor, the
// new key or its mirror slot, as the broadcast command selects.
// ----------------------------------------------------------------------------
`default_nettype none
module ole_cell
  import ole_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  wire                  clk,
  input  cmd_t                 cmd,
  input  wire                  at_pos,     // insert or delete lands here
  input  wire                  past_pos,   // cell lies beyond the edit point; in a reversal, inside the list
  input  wire [KEY_WIDTH-1:0]  new_key,
  input  wire [KEY_WIDTH-1:0]  left_key,
  input  wire [KEY_WIDTH-1:0]  right_key,
  input  wire [KEY_WIDTH-1:0]  mirror_key,
  output logic [KEY_WIDTH-1:0] key_r
);
  logic [KEY_WIDTH-1:0] key_nxt;

  // Select the next key for this slot.
  always_comb begin
    key_nxt = key_r;
    case (cmd)
      C_INS: begin
        if (at_pos) key_nxt = new_key;
        else if (past_pos) key_nxt = left_key;
      end
      C_DEL: if (at_pos || past_pos) key_nxt = right_key;
      C_REV: if (past_pos) key_nxt = mirror_key;
      C_SHL: key_nxt = right_key;
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end
endmodule
`default_nettype wire

[design/ordered_list_engine_core.sv]
// ----------------------------------------------------------------------------
// Ordered list engine core
// Sorted list of signed keys held in a chain of cells.
// ----------------------------------------------------------------------------
// Operation words enter on in_ (op, key_value); result words leave on out_.
// An edit compares the key against every cell at once to find the edit
// point and moves the cells in the same execute state. The status word then
// waits in the output register until it is taken, and the next operation
// is accepted in the cycle it leaves. Read-out shifts the chain toward the
// front one cell per word, recirculating the head to the tail, so a list
// of n entries gives n words (at most 16), one per cycle unless stalled,
// and ends back in its original order. Entries past the sixteenth are
// rotated back with no word out. An empty read-out gives one word with
// status empty. A stalled receiver simply holds the current word and the
// chain. Reset empties the list at once; stored keys are not cleared.
// Each accepted word finishes its results before the next is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module ordered_list_engine_core
  import ole_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input wire        clk,
  input wire        rst_n,
  ole_in_if.sink    in_ch,
  ole_out_if.source out_ch
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [3:0]           op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CW-1:0]        pos_r;
  logic [CW-1:0]        rd_n_r, rd_i_r;
  logic [1:0]           st_r, st_nxt;
  cmd_t                 cmd;
  logic [CW-1:0]        pos_sel;
  logic [KEY_WIDTH-1:0] keys [DEPTH];
  logic [DEPTH-1:0]     ge_v, eq_v;
  logic [CW-1:0]        ge_pos, eq_pos;
  logic                 eq_any;
  logic [CW-1:0]        rd_lim;

  // Parallel compares against every cell, priority to the front.
  always_comb begin
    ge_pos = cnt_r;
    eq_pos = '0;
    eq_any = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      ge_v[i] = (CW'(i) < cnt_r) && !($signed(keys[i]) < $signed(key_r));
      eq_v[i] = (CW'(i) < cnt_r) && (keys[i] == key_r);
      if (ge_v[i]) ge_pos = CW'(i);
      if (eq_v[i]) begin
        eq_pos = CW'(i);
        eq_any = 1'b1;
      end
    end
  end

  // Cell chain.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] lk, rk, mk;
    logic at_p, past_p;
    logic [CW:0] mi;
    always_comb begin
      lk = (g == 0) ? keys[0] : keys[(g == 0) ? 0 : g - 1];
      if (g == DEPTH - 1) rk = keys[0];
      else rk = keys[(g == DEPTH - 1) ? 0 : g + 1];
      if (cmd == C_SHL && CW'(g) + 1'b1 == cnt_r) rk = keys[0];
      mi = {1'b0, cnt_r} - (CW + 1)'(1) - (CW + 1)'(g);
      mk = keys[mi[PW-1:0]];
      at_p = (CW'(g) == pos_sel);
      if (cmd == C_REV) past_p = !mi[CW] && (CW'(g) < cnt_r);
      else past_p = (CW'(g) > pos_sel);
    end
    ole_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk(clk), .cmd(cmd), .at_pos(at_p), .past_pos(past_p),
      .new_key(key_r), .left_key(lk), .right_key(rk), .mirror_key(mk),
      .key_r(keys[g])
    );
  end

  // Number of words a read-out emits; only lists longer than that are cut.
  assign rd_lim = (DEPTH > MaxOut && cnt_r > CW'(MaxOut)) ? CW'(MaxOut) : cnt_r;

  // Controller: next state, cell command and status.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    cmd       = C_HOLD;
    pos_sel   = pos_r;
    in_ch.ready = (state_r == S_IDLE) || (state_r == S_RESP && out_ch.ready);
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_RESP;
        st_nxt = ST_OK;
        case (op_r)
          OP_CLEAR: cnt_nxt = '0;
          OP_SORTED, OP_INS_FR, OP_INS_BK: begin
            if (cnt_r >= CW'(DEPTH)) st_nxt = ST_FULL;
            else begin
              cmd = C_INS;
              pos_sel = (op_r == OP_INS_FR) ? '0 :
                        (op_r == OP_INS_BK) ? cnt_r : ge_pos;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          OP_DEL_KEY, OP_DEL_FR, OP_DEL_BK: begin
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else if (op_r == OP_DEL_KEY && !eq_any) st_nxt = ST_MISSING;
            else begin
              cmd = C_DEL;
              pos_sel = (op_r == OP_DEL_FR) ? '0 :
                        (op_r == OP_DEL_BK) ? cnt_r - 1'b1 : eq_pos;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          OP_REVERSE: cmd = C_REV;
          OP_READ: begin
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else state_nxt = S_READ;
          end
          default: st_nxt = ST_OK;
        endcase
      end
      S_RESP: begin
        if (out_ch.ready) state_nxt = in_ch.valid ? S_EXEC : S_IDLE;
      end
      S_READ: begin
        // Shift on each taken word, and freely once all words are out.
        if (out_ch.ready || rd_i_r >= rd_n_r) begin
          cmd = C_SHL;
          if (rd_i_r + 1'b1 == cnt_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output word.
  always_comb begin
    out_ch.valid          = (state_r == S_RESP) ||
                            (state_r == S_READ && rd_i_r < rd_n_r);
    out_ch.entry_key      = (state_r == S_READ) ? 32'(signed'(keys[0])) : '0;
    out_ch.entry_position = (state_r == S_READ) ? 4'(rd_i_r) : '0;
    out_ch.entry_count    = 5'(cnt_r);
    out_ch.status         = (state_r == S_READ) ? ST_OK : st_r;
    out_ch.last_result    = (state_r == S_READ) ? (rd_i_r + 1'b1 == rd_n_r) : 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload and read-out bookkeeping. A read of more than rd_n entries
  // still rotates the whole list back; the controller keeps shifting
  // with no word out until every entry has gone round.
  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.op;
      key_r <= KEY_WIDTH'(in_ch.key_value);
    end
    pos_r   <= pos_sel;
    if (state_r == S_EXEC) begin
      rd_n_r <= rd_lim;
      rd_i_r <= '0;
    end else if (cmd == C_SHL) begin
      rd_i_r <= rd_i_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

[sim/ordered_list_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// Ordered list engine core testbench
// Drives operation words with random idling on both channels, predicts the
// list contents and checks every result word in order against the
// prediction held by a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ordered_list_engine_core_tb
  import ole_pkg::*;
();

  localparam int LIST_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  // One result word as seen on the out_ channel.
  typedef struct packed {
    logic signed [31:0] key;
    logic [3:0]         pos;
    logic [4:0]         count;
    logic [1:0]         status;
    logic               last;
  } result_word_t;

  // Predicts the list and holds the result words still to come.
  class list_scoreboard;
    logic signed [31:0] keys[LIST_DEPTH];
    int                 count;
    result_word_t       pending[$];
    int                 errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void push_status(logic [1:0] st);
      result_word_t w;
      w = '{key: 0, pos: 0, count: count[4:0], status: st, last: 1'b1};
      pending.push_back(w);
    endfunction

    function void insert_at(int pos, logic signed [31:0] k);
      for (int i = count; i > pos; i--) keys[i] = keys[i - 1];
      keys[pos] = k;
      count++;
    endfunction

    function void remove_at(int pos);
      for (int i = pos; i + 1 < count; i++) keys[i] = keys[i + 1];
      count--;
    endfunction

    // Applies one accepted operation word and queues its results.
    function void note_word(logic [3:0] op, logic signed [31:0] k);
      int i;
      logic signed [31:0] t;
      logic [1:0] st;
      st = ST_OK;
      case (op)
        OP_CLEAR: count = 0;
        OP_SORTED, OP_INS_FR, OP_INS_BK: begin
          if (count >= LIST_DEPTH) begin
            st = ST_FULL;
          end else if (op == OP_INS_FR) begin
            insert_at(0, k);
          end else if (op == OP_INS_BK) begin
            insert_at(count, k);
          end else begin
            for (i = 0; i < count; i++) if (!(keys[i] < k)) break;
            insert_at(i, k);
          end
        end
        OP_DEL_KEY: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            for (i = 0; i < count; i++) if (keys[i] == k) break;
            if (i < count) remove_at(i);
            else st = ST_MISSING;
          end
        end
        OP_DEL_FR, OP_DEL_BK: begin
          if (count == 0) st = ST_EMPTY;
          else remove_at(op == OP_DEL_FR ? 0 : count - 1);
        end
        OP_REVERSE: begin
          for (i = 0; i < count / 2; i++) begin
            t = keys[i];
            keys[i] = keys[count - 1 - i];
            keys[count - 1 - i] = t;
          end
        end
        OP_READ: begin
          if (count == 0) st = ST_EMPTY;
          for (i = 0; i < count; i++)
            pending.push_back('{key: keys[i], pos: i[3:0], count: count[4:0],
                                status: ST_OK, last: (i == count - 1)});
        end
        default: ;
      endcase
      if (!(op == OP_READ && count > 0)) push_status(st);
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_word(result_word_t got);
      result_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp_w, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  list_scoreboard board;

  ole_in_if  in_ch();
  ole_out_if out_ch();

  ordered_list_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, checks each accepted word.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_word('{key: out_ch.entry_key, pos: out_ch.entry_position,
                         count: out_ch.entry_count, status: out_ch.status,
                         last: out_ch.last_result});
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sends one operation word, with a random gap before it.
  task automatic send_word(logic [3:0] op, logic signed [31:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= 4'($urandom);
      in_ch.key_value <= 32'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.key_value <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_word(op, k);
  endtask

  // Drops valid and drives random op and key values.
  task automatic idle_sender();
    in_ch.valid <= 1'b0;
    in_ch.op <= 4'($urandom);
    in_ch.key_value <= 32'($urandom);
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Keys drawn from a small pool often, so deletes hit, else anywhere.
  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $signed($urandom_range(12)) - 6;
    if (r == 5) return 32'sh7fffffff;
    if (r == 6) return 32'sh80000000;
    return $urandom;
  endfunction

  task automatic random_words(int n);
    int r;
    logic [3:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) op = OP_SORTED;
      else if (r < 47) op = OP_INS_FR;
      else if (r < 54) op = OP_INS_BK;
      else if (r < 66) op = OP_DEL_KEY;
      else if (r < 72) op = OP_DEL_FR;
      else if (r < 78) op = OP_DEL_BK;
      else if (r < 83) op = OP_REVERSE;
      else if (r < 95) op = OP_READ;
      else if (r < 97) op = OP_CLEAR;
      else op = 4'($urandom_range(15, 9));
      send_word(op, pick_key());
    end
  endtask

  initial begin
    board = new();
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.key_value = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-list cases, then extremes, a full list, overflow and reversal.
    send_word(OP_READ, 0);
    send_word(OP_DEL_KEY, 5);
    send_word(OP_DEL_FR, 0);
    send_word(OP_DEL_BK, 0);
    send_word(OP_REVERSE, 0);
    send_word(OP_CLEAR, 0);
    send_word(OP_SORTED, 32'sh7fffffff);
    send_word(OP_SORTED, 32'sh80000000);
    send_word(OP_SORTED, -1);
    send_word(OP_SORTED, -1);
    send_word(OP_INS_FR, 32'sh55555555);
    send_word(OP_INS_BK, 32'shaaaaaaaa);
    for (int i = 0; i < 10; i++) send_word(OP_SORTED, i);
    send_word(OP_INS_BK, 3);
    send_word(OP_REVERSE, 0);
    send_word(OP_READ, 0);
    send_word(OP_DEL_KEY, 1234);
    send_word(OP_DEL_KEY, -1);
    send_word(4'd15, 0);
    send_word(OP_CLEAR, 0);
    send_word(OP_INS_FR, 7);
    send_word(OP_DEL_KEY, 7);
    idle_sender();
    drain();

    send_idle_pct = 15;
    recv_idle_pct = 57;
    random_words(64);
    idle_sender();
    drain();
    send_idle_pct = 57;
    recv_idle_pct = 15;
    random_words(64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(64);

    idle_sender();
    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
